[rtl/core/pvc_pkg.sv]
// Shared types, constants and the step sequence for vertex_project_and_cull.
// Depends on nothing. Every other file in rtl/core uses it by scoped names.
`timescale 1ns / 1ps

package pvc_pkg;

  // Default parameter values
  localparam int NEAR_PLANE_DEF  = 410;
  localparam int SCREEN_BITS_DEF = 16;

  // Datapath widths
  localparam int CRD_W  = 24;  // world coordinate, Q11.12
  localparam int DIF_W  = 25;  // vertex minus camera
  localparam int ROT1_W = 28;  // after yaw rotation
  localparam int ROT2_W = 31;  // after pitch rotation
  localparam int K_W    = 30;  // window size times focal factor
  localparam int OPN_W  = 32;  // multiplier operand
  localparam int ACC_W  = 64;  // product and accumulator
  localparam int TRIG_W = 16;
  localparam int WIN_W  = 13;
  localparam int FOC_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int ROT_SHIFT  = 14;
  localparam int DEN_SHIFT  = 9;
  localparam int HALF_SHIFT = 8;

  // Step sequence length
  localparam int STEPS  = 21;
  localparam int STEP_W = 5;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAM_X      = 3'd0,
    REG_CAM_Y      = 3'd1,
    REG_CAM_Z      = 3'd2,
    REG_YAW_TRIG   = 3'd3,
    REG_PITCH_TRIG = 3'd4,
    REG_FOCAL      = 3'd5,
    REG_WIN_WIDTH  = 3'd6,
    REG_WIN_HEIGHT = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] vertex_x;
    logic signed [CRD_W-1:0] vertex_y;
    logic signed [CRD_W-1:0] vertex_z;
    logic                    last_vertex;
  } in_t;

  typedef struct packed {
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic               polygon_off_screen;
    logic               last;
  } out_t;

  // Multiplier operand pairs
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_DX_CY,
    MUL_DY_SY,
    MUL_DY_CY,
    MUL_DX_SY,
    MUL_Y2_CP,
    MUL_DZ_SP,
    MUL_Y2_SP,
    MUL_DZ_CP,
    MUL_W_F,
    MUL_W_YD,
    MUL_H_F,
    MUL_H_YD,
    MUL_K_X2,
    MUL_K_ZD
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_LOAD8,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef enum logic [2:0] {
    ST_NONE,
    ST_X2,
    ST_Y2,
    ST_YD,
    ST_ZD,
    ST_K
  } st_sel_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    st_sel_t  st_sel;
    logic     div_go;
    logic     div_y;
  } uop_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    uop_t uop;
    logic emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;
    logic out_free;
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DIV,
    ST_EMIT
  } state_t;

  // One step of the transform. The product register holds the product issued
  // on the previous step; stores read the accumulator as it stood at step start.
  function automatic uop_t step_uop(input logic [STEP_W-1:0] step);
    uop_t u;
    u = '{mul_sel: MUL_NONE, acc_op: ACC_HOLD, st_sel: ST_NONE,
          div_go: 1'b0, div_y: 1'b0};
    unique case (step)
      5'd0:  u.mul_sel = MUL_DX_CY;
      5'd1:  begin u.mul_sel = MUL_DY_SY; u.acc_op = ACC_LOAD; end
      5'd2:  begin u.mul_sel = MUL_DY_CY; u.acc_op = ACC_SUB; end
      5'd3:  begin u.mul_sel = MUL_DX_SY; u.acc_op = ACC_LOAD; u.st_sel = ST_X2; end
      5'd4:  u.acc_op = ACC_ADD;
      5'd5:  u.st_sel = ST_Y2;
      5'd6:  u.mul_sel = MUL_Y2_CP;
      5'd7:  begin u.mul_sel = MUL_DZ_SP; u.acc_op = ACC_LOAD; end
      5'd8:  begin u.mul_sel = MUL_Y2_SP; u.acc_op = ACC_SUB; end
      5'd9:  begin u.mul_sel = MUL_DZ_CP; u.acc_op = ACC_LOAD; u.st_sel = ST_YD; end
      5'd10: u.acc_op = ACC_ADD;
      5'd11: begin u.mul_sel = MUL_W_F; u.st_sel = ST_ZD; end
      5'd12: begin u.mul_sel = MUL_W_YD; u.st_sel = ST_K; end
      5'd13: begin u.mul_sel = MUL_K_X2; u.acc_op = ACC_LOAD8; end
      5'd14: u.acc_op = ACC_ADD;
      5'd15: u.div_go = 1'b1;
      5'd16: u.mul_sel = MUL_H_F;
      5'd17: begin u.mul_sel = MUL_H_YD; u.st_sel = ST_K; end
      5'd18: begin u.mul_sel = MUL_K_ZD; u.acc_op = ACC_LOAD8; end
      5'd19: u.acc_op = ACC_SUB;
      5'd20: begin u.div_go = 1'b1; u.div_y = 1'b1; end
      default: ;
    endcase
    return u;
  endfunction

endpackage

[rtl/core/pvc_div.sv]
// Restoring divider with saturation to a signed SCREEN_BITS result.
// Depends on pvc_pkg. One quotient bit per cycle, truncation toward zero.
`timescale 1ns / 1ps

module pvc_div #(
  parameter int SCREEN_BITS = pvc_pkg::SCREEN_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic signed [pvc_pkg::ACC_W-1:0]       num,
  input  logic        [pvc_pkg::ACC_W-1:0]       den,
  output logic                                   done,
  output logic signed [SCREEN_BITS-1:0]          quot
);

  localparam int CNT_W = $clog2(SCREEN_BITS + 1);

  logic [pvc_pkg::ACC_W-1:0] rem_r, rem_nxt;
  logic [pvc_pkg::ACC_W-1:0] dsh_r, dsh_nxt;
  logic [SCREEN_BITS-1:0]    q_r, q_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      neg_r, neg_nxt;
  logic                      ovf_r, ovf_nxt;
  logic                      done_r, done_nxt;
  logic [pvc_pkg::ACC_W-1:0] mag;
  logic                      ge;
  logic [SCREEN_BITS-1:0]    q_neg;
  logic [SCREEN_BITS-1:0]    sat_hi, sat_lo;

  assign mag = num[pvc_pkg::ACC_W-1] ? (~num + 1'b1) : num;
  assign ge  = (rem_r >= dsh_r);

  // Load on start, then one compare and subtract per cycle
  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    ovf_nxt  = ovf_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = mag;
      dsh_nxt = den << (SCREEN_BITS - 1);
      q_nxt   = '0;
      cnt_nxt = CNT_W'(SCREEN_BITS);
      neg_nxt = num[pvc_pkg::ACC_W-1];
      ovf_nxt = (mag >= (den << SCREEN_BITS));
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? (rem_r - dsh_r) : rem_r;
      dsh_nxt  = dsh_r >> 1;
      q_nxt    = {q_r[SCREEN_BITS-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
    neg_r <= neg_nxt;
    ovf_r <= ovf_nxt;
  end

  // Saturate the signed quotient
  assign sat_hi = {1'b0, {(SCREEN_BITS-1){1'b1}}};
  assign sat_lo = {1'b1, {(SCREEN_BITS-1){1'b0}}};
  assign q_neg  = ~q_r + 1'b1;

  always_comb begin
    if (!neg_r) begin
      quot = (ovf_r || q_r[SCREEN_BITS-1]) ? sat_hi : q_r;
    end else begin
      quot = (ovf_r || (q_r[SCREEN_BITS-1] && (|q_r[SCREEN_BITS-2:0]))) ? sat_lo : q_neg;
    end
  end

  assign done = done_r;

endmodule

[rtl/core/pvc_ctrl.sv]
// Controller for vertex_project_and_cull: request handshake and step sequence.
// Depends on pvc_pkg. Drives the datapath by cmd_t, reads status_t back.
`timescale 1ns / 1ps

module pvc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pvc_pkg::status_t  status,
  output pvc_pkg::cmd_t     cmd
);

  pvc_pkg::state_t                 state_r, state_nxt;
  logic [pvc_pkg::STEP_W-1:0]      step_r, step_nxt;
  pvc_pkg::uop_t                   uop;

  assign uop = pvc_pkg::step_uop(step_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      pvc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = pvc_pkg::ST_RUN;
          step_nxt  = '0;
        end
      end
      pvc_pkg::ST_RUN: begin
        step_nxt = step_r + 1'b1;
        if (uop.div_go) begin
          state_nxt = pvc_pkg::ST_DIV;
        end
      end
      pvc_pkg::ST_DIV: begin
        if (status.div_done) begin
          state_nxt = (step_r == pvc_pkg::STEP_W'(pvc_pkg::STEPS)) ?
                      pvc_pkg::ST_EMIT : pvc_pkg::ST_RUN;
        end
      end
      pvc_pkg::ST_EMIT: begin
        if (status.out_free) begin
          state_nxt = pvc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pvc_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.emit    = 1'b0;
    cmd.uop     = '{mul_sel: pvc_pkg::MUL_NONE, acc_op: pvc_pkg::ACC_HOLD,
                    st_sel: pvc_pkg::ST_NONE, div_go: 1'b0, div_y: 1'b0};
    unique case (state_r)
      pvc_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      pvc_pkg::ST_RUN:  cmd.uop = uop;
      pvc_pkg::ST_DIV:  ;
      pvc_pkg::ST_EMIT: cmd.emit = status.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pvc_pkg::ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

[rtl/core/pvc_dp.sv]
// Datapath for vertex_project_and_cull: config registers, shared multiplier,
// accumulator, divider, cull mask and output register. Depends on pvc_pkg, pvc_div.
`timescale 1ns / 1ps

module pvc_dp #(
  parameter int NEAR_PLANE  = pvc_pkg::NEAR_PLANE_DEF,
  parameter int SCREEN_BITS = pvc_pkg::SCREEN_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pvc_pkg::cmd_t                      cmd,
  output pvc_pkg::status_t                   status,
  input  pvc_pkg::in_t                       in_data,
  input  logic                               cfg_valid,
  input  logic [pvc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pvc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output pvc_pkg::out_t                      out_data
);

  localparam int DW = pvc_pkg::DIF_W;
  localparam int R1 = pvc_pkg::ROT1_W;
  localparam int R2 = pvc_pkg::ROT2_W;
  localparam int OW = pvc_pkg::OPN_W;
  localparam int AW = pvc_pkg::ACC_W;

  // Configuration registers
  logic signed [pvc_pkg::CRD_W-1:0] cam_x_r, cam_y_r, cam_z_r;
  logic [31:0]                      yaw_r, pitch_r;
  logic [pvc_pkg::FOC_W-1:0]        focal_r;
  logic [pvc_pkg::WIN_W-1:0]        win_w_r, win_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r <= '0;
      cam_y_r <= '0;
      cam_z_r <= '0;
      yaw_r   <= 32'h4000_0000;
      pitch_r <= 32'h4000_0000;
      focal_r <= 16'd256;
      win_w_r <= 13'd640;
      win_h_r <= 13'd480;
    end else if (cfg_valid) begin
      unique case (pvc_pkg::cfg_reg_t'(cfg_index))
        pvc_pkg::REG_CAM_X:      cam_x_r <= cfg_data[pvc_pkg::CRD_W-1:0];
        pvc_pkg::REG_CAM_Y:      cam_y_r <= cfg_data[pvc_pkg::CRD_W-1:0];
        pvc_pkg::REG_CAM_Z:      cam_z_r <= cfg_data[pvc_pkg::CRD_W-1:0];
        pvc_pkg::REG_YAW_TRIG:   yaw_r   <= cfg_data;
        pvc_pkg::REG_PITCH_TRIG: pitch_r <= cfg_data;
        pvc_pkg::REG_FOCAL:      focal_r <= cfg_data[pvc_pkg::FOC_W-1:0];
        pvc_pkg::REG_WIN_WIDTH:  win_w_r <= cfg_data[pvc_pkg::WIN_W-1:0];
        pvc_pkg::REG_WIN_HEIGHT: win_h_r <= cfg_data[pvc_pkg::WIN_W-1:0];
        default: ;
      endcase
    end
  end

  logic signed [pvc_pkg::TRIG_W-1:0] cy, sy, cp, sp;
  assign cy = yaw_r[31:16];
  assign sy = yaw_r[15:0];
  assign cp = pitch_r[31:16];
  assign sp = pitch_r[15:0];

  // Capture the camera-relative vertex
  logic signed [DW-1:0] dx_r, dy_r, dz_r;
  logic                 last_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      dx_r   <= DW'(in_data.vertex_x) - DW'(cam_x_r);
      dy_r   <= DW'(in_data.vertex_y) - DW'(cam_y_r);
      dz_r   <= DW'(in_data.vertex_z) - DW'(cam_z_r);
      last_r <= in_data.last_vertex;
    end
  end

  // Shared multiplier
  logic signed [R1-1:0] x2_r, y2_r;
  logic signed [R2-1:0] yd_r, zd_r;
  logic [pvc_pkg::K_W-1:0] k_r;
  logic signed [OW-1:0] opa, opb;
  logic signed [AW-1:0] prod_w, prod_r, acc_r;

  always_comb begin
    opa = '0;
    opb = '0;
    unique case (cmd.uop.mul_sel)
      pvc_pkg::MUL_NONE:  ;
      pvc_pkg::MUL_DX_CY: begin opa = OW'(dx_r); opb = OW'(cy); end
      pvc_pkg::MUL_DY_SY: begin opa = OW'(dy_r); opb = OW'(sy); end
      pvc_pkg::MUL_DY_CY: begin opa = OW'(dy_r); opb = OW'(cy); end
      pvc_pkg::MUL_DX_SY: begin opa = OW'(dx_r); opb = OW'(sy); end
      pvc_pkg::MUL_Y2_CP: begin opa = OW'(y2_r); opb = OW'(cp); end
      pvc_pkg::MUL_DZ_SP: begin opa = OW'(dz_r); opb = OW'(sp); end
      pvc_pkg::MUL_Y2_SP: begin opa = OW'(y2_r); opb = OW'(sp); end
      pvc_pkg::MUL_DZ_CP: begin opa = OW'(dz_r); opb = OW'(cp); end
      pvc_pkg::MUL_W_F:   begin opa = OW'($signed({1'b0, win_w_r}));
                                opb = OW'($signed({1'b0, focal_r})); end
      pvc_pkg::MUL_W_YD:  begin opa = OW'($signed({1'b0, win_w_r})); opb = OW'(yd_r); end
      pvc_pkg::MUL_H_F:   begin opa = OW'($signed({1'b0, win_h_r}));
                                opb = OW'($signed({1'b0, focal_r})); end
      pvc_pkg::MUL_H_YD:  begin opa = OW'($signed({1'b0, win_h_r})); opb = OW'(yd_r); end
      pvc_pkg::MUL_K_X2:  begin opa = OW'($signed({1'b0, k_r})); opb = OW'(x2_r); end
      pvc_pkg::MUL_K_ZD:  begin opa = OW'($signed({1'b0, k_r})); opb = OW'(zd_r); end
      default: ;
    endcase
  end

  assign prod_w = opa * opb;

  always_ff @(posedge clk) begin
    prod_r <= prod_w;
  end

  // Accumulate products
  always_ff @(posedge clk) begin
    unique case (cmd.uop.acc_op)
      pvc_pkg::ACC_HOLD:  ;
      pvc_pkg::ACC_LOAD:  acc_r <= prod_r;
      pvc_pkg::ACC_LOAD8: acc_r <= prod_r <<< pvc_pkg::HALF_SHIFT;
      pvc_pkg::ACC_ADD:   acc_r <= acc_r + prod_r;
      pvc_pkg::ACC_SUB:   acc_r <= acc_r - prod_r;
      default: ;
    endcase
  end

  // Store rotated coordinates, clamp depth to the near plane
  logic signed [AW-1:0] acc_sh;
  logic signed [R2-1:0] yd_raw;
  assign acc_sh = acc_r >>> pvc_pkg::ROT_SHIFT;
  assign yd_raw = acc_sh[R2-1:0];

  always_ff @(posedge clk) begin
    unique case (cmd.uop.st_sel)
      pvc_pkg::ST_NONE: ;
      pvc_pkg::ST_X2:   x2_r <= acc_sh[R1-1:0];
      pvc_pkg::ST_Y2:   y2_r <= acc_sh[R1-1:0];
      pvc_pkg::ST_YD:   yd_r <= (yd_raw < R2'(NEAR_PLANE)) ? R2'(NEAR_PLANE) : yd_raw;
      pvc_pkg::ST_ZD:   zd_r <= acc_sh[R2-1:0];
      pvc_pkg::ST_K:    k_r  <= prod_r[pvc_pkg::K_W-1:0];
      default: ;
    endcase
  end

  // Divide by 512 times depth
  logic [AW-1:0]                 den;
  logic                          div_done;
  logic signed [SCREEN_BITS-1:0] quot;
  logic                          div_y_r;
  logic signed [SCREEN_BITS-1:0] sx_r, sy_r;

  assign den = AW'($unsigned(yd_r)) << pvc_pkg::DEN_SHIFT;

  pvc_div #(
    .SCREEN_BITS (SCREEN_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.uop.div_go),
    .num   (acc_r),
    .den   (den),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.uop.div_go) begin
      div_y_r <= cmd.uop.div_y;
    end
    if (div_done) begin
      if (div_y_r) begin
        sy_r <= quot;
      end else begin
        sx_r <= quot;
      end
    end
  end

  // Side tests and polygon mask
  logic signed [31:0] sx_ext, sy_ext;
  logic [3:0]         sides, sides_r, sides_and;
  logic               out_valid_r;
  pvc_pkg::out_t      out_r;

  assign sx_ext = 32'(sx_r);
  assign sy_ext = 32'(sy_r);

  always_comb begin
    sides[0]  = (sx_ext < 0);
    sides[1]  = (sy_ext < 0);
    sides[2]  = (sx_ext > $signed({19'b0, win_w_r}));
    sides[3]  = (sy_ext > $signed({19'b0, win_h_r}));
    sides_and = sides_r & sides;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sides_r     <= 4'hF;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.emit) begin
        sides_r     <= last_r ? 4'hF : sides_and;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (cmd.emit) begin
      out_r.screen_x           <= sx_ext[15:0];
      out_r.screen_y           <= sy_ext[15:0];
      out_r.polygon_off_screen <= last_r & (|sides_and);
      out_r.last               <= last_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data        = out_r;
  assign status.div_done = div_done;
  assign status.out_free = !out_valid_r || out_ready;

endmodule

[rtl/core/vertex_project_and_cull.sv]
// Top level of vertex_project_and_cull: controller plus datapath.
// Depends on pvc_pkg, pvc_ctrl, pvc_dp (and pvc_div below it).
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   in      | in_valid in_ready in_data        | request in
//   out     | out_valid out_ready out_data     | request out
//   cfg     | cfg_valid cfg_ready cfg_index    | write in
//           | cfg_data                         |
//
// A vertex passes from acceptance to the output register through twenty-one
// sequencer steps around the one shared 32x32 multiplier, with two bit-serial
// divisions, one for each screen coordinate, and a final emit state. The next
// request is taken in the idle state only once the emit is done, so a new vertex
// is not accepted before the last one is through.
// Reset is synchronous, active low; it restores the register defaults and the
// polygon side mask. A result held in the output register does not block the
// next request; a second result waits until the first is taken.
`timescale 1ns / 1ps

module vertex_project_and_cull #(
  parameter int NEAR_PLANE  = pvc_pkg::NEAR_PLANE_DEF,
  parameter int SCREEN_BITS = pvc_pkg::SCREEN_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  pvc_pkg::in_t                       in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output pvc_pkg::out_t                      out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pvc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pvc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  pvc_pkg::cmd_t    cmd;
  pvc_pkg::status_t status;

  assign cfg_ready = 1'b1;

  pvc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pvc_dp #(
    .NEAR_PLANE  (NEAR_PLANE),
    .SCREEN_BITS (SCREEN_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
